### src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned PRI_W = 16;
	localparam int unsigned FILL_W = 5;

	typedef logic [1:0] status_t;

	localparam status_t ST_INSERTED = 2'd0;
	localparam status_t ST_REMOVED = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;
	localparam status_t ST_FULL = 2'd3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	// Broadcast to every cell of the chain for one accepted item.
	typedef struct packed {
		logic ins;
		logic del;
		logic signed [VAL_W-1:0] value;
		logic signed [PRI_W-1:0] prio;
	} cell_ctrl_t;

endpackage

### src/spq_cell.sv
// One slot of the sorted chain: holds an entry and compares it with a new one.
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
(
	input  logic clk,
	input  cell_ctrl_t ctrl,
	input  logic occ,
	input  logic left_gt,
	input  logic signed [VAL_W-1:0] left_value,
	input  logic signed [PRI_W-1:0] left_priority,
	input  logic signed [VAL_W-1:0] right_value,
	input  logic signed [PRI_W-1:0] right_priority,
	output logic gt,
	output logic signed [VAL_W-1:0] value,
	output logic signed [PRI_W-1:0] prio
);

	logic signed [VAL_W-1:0] value_q;
	logic signed [PRI_W-1:0] priority_q;

	// An empty slot counts as greater, so the new entry lands after all equal ones.
	assign gt = !occ || (priority_q > ctrl.prio);
	assign value = value_q;
	assign prio = priority_q;

	always_ff @(posedge clk) begin
		if (ctrl.del) begin
			value_q <= right_value;
			priority_q <= right_priority;
		end else if (ctrl.ins && gt) begin
			if (left_gt) begin
				value_q <= left_value;
				priority_q <= left_priority;
			end else begin
				value_q <= ctrl.value;
				priority_q <= ctrl.prio;
			end
		end
	end

endmodule

### src/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: cell chain, fill count and result register.
`timescale 1ns / 1ps

// Sorted priority queue built as a chain of DEPTH cells, kept in ascending
// priority order with the front entry in the first cell. Every cell compares
// its entry with an incoming one and shifts or loads in the same cycle, so the
// queue takes one insert or delete item every clock while in_stall is low, and
// presents its result in the cycle after the item is accepted; the compare
// and shift in each cell sets the rate. A finished result waits in an output
// register, and a new item is still taken while it waits unless out_stall is set.

module sorted_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  logic signed [VAL_W-1:0] item_value,
	input  logic signed [PRI_W-1:0] item_priority,
	output logic out_valid,
	input  logic out_stall,
	output status_t status,
	output logic signed [VAL_W-1:0] out_value,
	output logic signed [PRI_W-1:0] out_priority,
	output logic [FILL_W-1:0] fill_count
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	status_t status_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic signed [PRI_W-1:0] out_priority_q;

	logic accept;
	logic full;
	logic empty;
	cell_ctrl_t ctrl;
	status_t next_status;
	logic [CNT_W-1:0] next_cnt;
	logic [CNT_W+FILL_W-1:0] cnt_wide;

	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] gt;
	logic signed [VAL_W-1:0] cell_value [DEPTH];
	logic signed [PRI_W-1:0] cell_priority [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;
	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

	always_comb begin
		ctrl.ins = accept && (req_type == REQ_INSERT) && !full;
		ctrl.del = accept && (req_type == REQ_DELETE) && !empty;
		ctrl.value = item_value;
		ctrl.prio = item_priority;
	end

	always_comb begin
		next_cnt = cnt_q;
		if (req_type == REQ_INSERT) begin
			next_status = full ? ST_FULL : ST_INSERTED;
			if (!full) begin
				next_cnt = cnt_q + CNT_W'(1);
			end
		end else begin
			next_status = empty ? ST_UNDERFLOW : ST_REMOVED;
			if (!empty) begin
				next_cnt = cnt_q - CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic lgt;
		logic signed [VAL_W-1:0] lval;
		logic signed [PRI_W-1:0] lpri;
		logic signed [VAL_W-1:0] rval;
		logic signed [PRI_W-1:0] rpri;

		assign occ[i] = (CNT_W'(i) < cnt_q);

		if (i == 0) begin : g_first
			assign lgt = 1'b0;
			assign lval = '0;
			assign lpri = '0;
		end else begin : g_mid
			assign lgt = gt[i-1];
			assign lval = cell_value[i-1];
			assign lpri = cell_priority[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rval = '0;
			assign rpri = '0;
		end else begin : g_inner
			assign rval = cell_value[i+1];
			assign rpri = cell_priority[i+1];
		end

		spq_cell u_cell (
			.clk            (clk),
			.ctrl           (ctrl),
			.occ            (occ[i]),
			.left_gt        (lgt),
			.left_value     (lval),
			.left_priority  (lpri),
			.right_value    (rval),
			.right_priority (rpri),
			.gt             (gt[i]),
			.value          (cell_value[i]),
			.prio           (cell_priority[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= next_cnt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= next_status;
			out_value_q <= ctrl.del ? cell_value[0] : '0;
			out_priority_q <= ctrl.del ? cell_priority[0] : '0;
		end
	end

	assign cnt_wide = {{FILL_W{1'b0}}, cnt_q};

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_value = out_value_q;
	assign out_priority = out_priority_q;
	assign fill_count = cnt_wide[FILL_W-1:0];

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds the queue depth");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_type == REQ_DELETE) && empty |=>
			out_valid && (status == ST_UNDERFLOW) && (cnt_q == '0))
		else $error("delete from an empty queue did not report underflow");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_type == REQ_INSERT) && !full |=>
			(cnt_q == $past(cnt_q) + CNT_W'(1)) && (status == ST_INSERTED))
		else $error("accepted insert did not grow the queue by one");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_type == REQ_DELETE) && !empty |=>
			(cnt_q == $past(cnt_q) - CNT_W'(1)) && (status == ST_REMOVED)
			&& (out_priority == $past(cell_priority[0])))
		else $error("accepted delete did not return the front entry");
`endif

endmodule
